### sv/mh3_pkg.sv
package mh3_pkg;

    // Mixing constants
    localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2     = 32'h1b873593;
    localparam logic [31:0] FOLD_ADD   = 32'he6546b64;
    localparam logic [31:0] FIN_C1     = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2     = 32'hc2b2ae35;
    localparam logic [31:0] SEED_RESET = 32'd35;

    // Register map
    localparam int          ADDR_W    = 2;
    localparam logic [2:0]  FULL_WORD = 3'd4;

    // Controller to datapath commands, at most one per cycle
    typedef struct packed {
        logic load;    // capture input transfer
        logic mix1;    // k * C1
        logic mix2;    // rotl(k,15) * C2
        logic fold;    // fold key into accumulator, count length
        logic fin0;    // first finalizer multiply
        logic fin1;    // second finalizer multiply
        logic emit;    // write output register, reload seed
    } mh3_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;      // captured word ends the message
        logic out_free;  // output register can take a new hash
    } mh3_status_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction

endpackage

### sv/murmur3_hash_32.sv
// Channel   | Dir | Signals                          | Contents
// s_axis    | in  | s_tvalid s_tready s_tdata        | data_word, byte_count in tuser,
//           |     | s_tuser s_tlast                  | last_word on tlast
// m_axis    | out | m_tvalid m_tready m_tdata        | hash_value
// apb       | in  | psel penable pwrite paddr pwdata | seed at byte address 0
//
// A word passes from transfer through two registered key multiplies, then the
// accumulator fold, before the next accept; a last word adds the two finalizer
// multiplies and the output write, which waits for the output register to free up.
// The datapath does at most one 32x32 multiply per cycle.
// Reset clears the controller, length and output valid; seed returns to 35.
// A hash waiting on m_tready does not block input; only the next hash's
// output write waits for the register to free up.
module murmur3_hash_32
(
    input  logic                        clk,
    input  logic                        rst_n,
    // slave stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] data_word
    input  logic [2:0]                  s_tuser,   // [2:0] byte_count
    input  logic                        s_tlast,
    // master stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] hash_value
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mh3_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mh3_pkg::*;

    mh3_cmd_t    cmd;
    mh3_status_t status;
    logic        seed_we;
    logic [31:0] seed;
    logic [ADDR_W-1:0] addr_unused;

    // APB: single register, every address in range maps to seed
    assign pready      = 1'b1;
    assign seed_we     = psel && penable && pwrite && pready;
    assign addr_unused = paddr;
    assign prdata      = (addr_unused[ADDR_W-1] == 1'b0) ? seed : seed;

    mh3_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mh3_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .seed_we    (seed_we),
        .seed_wdata (pwdata),
        .seed       (seed)
    );

endmodule

### sv/mh3_ctrl.sv
module mh3_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mh3_pkg::mh3_status_t status,
    output mh3_pkg::mh3_cmd_t    cmd
);
    import mh3_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_FOLD,
        ST_FIN0,
        ST_FIN1,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_MIX1;
            ST_MIX1: state_next = ST_MIX2;
            ST_MIX2: state_next = ST_FOLD;
            ST_FOLD: state_next = status.last ? ST_FIN0 : ST_IDLE;
            ST_FIN0: state_next = ST_FIN1;
            ST_FIN1: state_next = ST_EMIT;
            ST_EMIT: if (status.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command decode
    always_comb
    begin
        cmd      = '0;
        cmd.load = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mix1 = (state_reg == ST_MIX1);
        cmd.mix2 = (state_reg == ST_MIX2);
        cmd.fold = (state_reg == ST_FOLD);
        cmd.fin0 = (state_reg == ST_FIN0);
        cmd.fin1 = (state_reg == ST_FIN1);
        cmd.emit = (state_reg == ST_EMIT) && status.out_free;
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

### sv/mh3_datapath.sv
module mh3_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mh3_pkg::mh3_cmd_t    cmd,
    output mh3_pkg::mh3_status_t status,
    input  logic [31:0]          s_tdata,
    input  logic [2:0]           s_tuser,
    input  logic                 s_tlast,
    output logic [31:0]          m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 seed_we,
    input  logic [31:0]          seed_wdata,
    output logic [31:0]          seed
);
    import mh3_pkg::*;

    logic [31:0] key_reg;
    logic [2:0]  count_reg;
    logic        last_reg;
    logic [31:0] acc_reg;
    logic [31:0] len_reg;
    logic [31:0] hash_reg;
    logic [31:0] out_reg;
    logic        out_valid_reg;
    logic        busy_reg;
    logic [31:0] seed_reg;

    logic [2:0]  count_sat;
    logic [31:0] word_masked;
    logic [31:0] acc_xor;
    logic [31:0] acc_rot;
    logic [31:0] acc_fold;
    logic [31:0] fin_x;
    logic [31:0] fin_a;
    logic [31:0] fin_b;

    // Byte count: non-last and out-of-range counts take the full word
    always_comb
    begin
        count_sat = s_tuser;
        if (!s_tlast || (s_tuser > FULL_WORD))
            count_sat = FULL_WORD;
        unique case (count_sat)
            3'd0:    word_masked = 32'h0;
            3'd1:    word_masked = {24'h0, s_tdata[7:0]};
            3'd2:    word_masked = {16'h0, s_tdata[15:0]};
            3'd3:    word_masked = {8'h0, s_tdata[23:0]};
            default: word_masked = s_tdata;
        endcase
    end

    // Fold and finalizer combinational terms
    assign acc_xor  = acc_reg ^ key_reg;
    assign acc_rot  = rotl32(acc_xor, 13);
    assign acc_fold = (acc_rot << 2) + acc_rot + FOLD_ADD;
    assign fin_x    = acc_reg ^ len_reg;
    assign fin_a    = fin_x ^ (fin_x >> 16);
    assign fin_b    = hash_reg ^ (hash_reg >> 13);

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= word_masked;
            count_reg <= count_sat;
            last_reg  <= s_tlast;
        end
        else if (cmd.mix1)
        begin
            key_reg <= 32'(key_reg * MIX_C1);
        end
        else if (cmd.mix2)
        begin
            key_reg <= 32'(rotl32(key_reg, 15) * MIX_C2);
        end

        if (cmd.fin0)
        begin
            hash_reg <= 32'(fin_a * FIN_C1);
        end
        else if (cmd.fin1)
        begin
            hash_reg <= 32'(fin_b * FIN_C2);
        end

        if (cmd.emit)
        begin
            out_reg <= hash_reg ^ (hash_reg >> 16);
        end
    end

    // Message state, seed and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= SEED_RESET;
            len_reg       <= '0;
            busy_reg      <= 1'b0;
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fold)
            begin
                acc_reg  <= (count_reg == FULL_WORD) ? acc_fold : acc_xor;
                len_reg  <= len_reg + {29'h0, count_reg};
                busy_reg <= 1'b1;
            end
            else if (cmd.emit)
            begin
                acc_reg  <= seed_reg;
                len_reg  <= '0;
                busy_reg <= 1'b0;
            end

            if (seed_we)
            begin
                seed_reg <= seed_wdata;
                if (!busy_reg)
                    acc_reg <= seed_wdata;
            end

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tdata         = out_reg;
    assign m_tvalid        = out_valid_reg;
    assign seed            = seed_reg;

    // Commands are exclusive
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    // A finished hash is never overwritten before its transfer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");

    // After a hash is emitted the length restarts and no message is open
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (len_reg == 32'h0) && !busy_reg && out_valid_reg)
        else $error("message state not cleared after emit");

endmodule

### tb/sv/murmur3_hash_32_tb.sv
module murmur3_hash_32_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mh3_pkg::*;

    localparam logic [ADDR_W-1:0] SEED_ADDR = '0;
    localparam int                CYCLE_LIMIT = 600000;
    localparam int                SETTLE_CYCLES = 12;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;     // [31:0] data_word
    logic [2:0]          s_tuser = '0;     // [2:0] byte_count
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;          // [31:0] hash_value
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Shadow copy of the hashing state
    logic [31:0]         seed_reg = SEED_RESET;
    logic [31:0]         hash_acc = SEED_RESET;
    logic [31:0]         byte_total = '0;
    bit                  in_msg = 1'b0;
    logic [31:0]         pending_hashes[$];

    bit                  idle_on = 1'b0;
    int                  stall_left = 0;
    int                  err_count = 0;
    int                  cycle_count = 0;

    murmur3_hash_32 DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // Key scramble: times C1, rotate left 15, times C2
    function automatic logic [31:0] scramble_key(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = {t[16:0], t[31:17]};
        return t * MIX_C2;
    endfunction

    // Final avalanche of the accumulator
    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FIN_C1;
        t = t ^ (t >> 13);
        t = t * FIN_C2;
        return t ^ (t >> 16);
    endfunction

    // Update shadow state with one accepted word; queue the hash on a last word
    task automatic absorb_word(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
        logic [2:0]  nbytes;
        logic [31:0] k;
        nbytes = (!lst || cnt > FULL_WORD) ? FULL_WORD : cnt;
        if (nbytes == FULL_WORD)
        begin
            hash_acc = hash_acc ^ scramble_key(w);
            hash_acc = {hash_acc[18:0], hash_acc[31:19]};
            hash_acc = hash_acc * 32'd5 + FOLD_ADD;
        end
        else if (nbytes != 3'd0)
        begin
            k = w & ((32'h1 << (8 * nbytes)) - 32'h1);
            hash_acc = hash_acc ^ scramble_key(k);
        end
        byte_total = byte_total + 32'(nbytes);
        if (lst)
        begin
            pending_hashes.push_back(avalanche(hash_acc ^ byte_total));
            hash_acc = seed_reg;
            byte_total = '0;
            in_msg = 1'b0;
        end
        else
            in_msg = 1'b1;
    endtask

    // Send one word; tvalid stays high on return so back-to-back words need no gap
    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= cnt;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        absorb_word(w, cnt, lst);
    endtask

    task automatic stream_hold();
        s_tvalid <= 1'b0;
    endtask

    // Wait for every hash to come out, then let any word still in flight settle
    task automatic wait_drained();
        while (pending_hashes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr == SEED_ADDR)
        begin
            seed_reg = value;
            if (!in_msg)
                hash_acc = value;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [ADDR_W-1:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("seed readback got %08h want %08h", prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_seed(input logic [31:0] value);
        stream_hold();
        wait_drained();
        apb_write(SEED_ADDR, value);
        apb_read_check(SEED_ADDR, value);
    endtask

    // Mostly random words, with the all-zero and all-one patterns mixed in
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Hash checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_hashes.size() == 0)
                report_mismatch($sformatf("unexpected hash %08h", m_tdata));
            else if (m_tdata !== pending_hashes[0])
            begin
                report_mismatch($sformatf("hash_value got %08h want %08h",
                                          m_tdata, pending_hashes[0]));
                void'(pending_hashes.pop_front());
            end
            else
                void'(pending_hashes.pop_front());
        end
    end

    // Output back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end
        else
        begin
            m_tready   <= 1'b1;
            stall_left <= idle_on ? $urandom_range(0, 11) : 0;
        end
    end

    // Reset value of the seed, empty message, one full word
    task automatic test_reset_seed();
        apb_read_check(SEED_ADDR, SEED_RESET);
        send_word($urandom, 3'd0, 1'b1);
        send_word($urandom, 3'd4, 1'b1);
    endtask

    // Tail lengths on the last word, including saturated counts; upper bytes are set
    // so masking and unsigned tail bytes both show up
    task automatic test_tail_counts();
        for (int c = 1; c <= 7; c++)
            send_word(32'hffff_ffff, 3'(c), 1'b1);
    endtask

    // Non-last words count four bytes whatever their count says
    task automatic test_nonlast_counts();
        send_word($urandom, 3'd0, 1'b0);
        send_word($urandom, 3'd7, 1'b0);
        send_word($urandom, 3'd2, 1'b1);
    endtask

    task automatic test_data_extremes();
        send_word(32'h0000_0000, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
    endtask

    task automatic test_seed_extremes();
        set_seed(32'h0000_0000);
        send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd3, 1'b1);
        set_seed(32'hffff_ffff);
        send_word(32'h0000_0000, 3'd1, 1'b1);
    endtask

    // Seed changes while a message is open take effect on the next message
    task automatic test_seed_mid_message();
        send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b0);
        set_seed(32'h1234_5678);
        send_word($urandom, 3'd1, 1'b1);
        send_word($urandom, 3'd4, 1'b1);
    endtask

    // Random messages; a few are noisy (odd counts on non-last words, oversized tails)
    task automatic test_random_traffic(input int n_items, input bit with_idle);
        int  sent;
        int  words;
        bit  noisy;
        sent = 0;
        idle_on = with_idle;
        while (sent < n_items)
        begin
            words = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            noisy = ($urandom_range(0, 6) == 0);
            for (int i = 0; i < words; i++)
            begin
                if (i == words - 1)
                    send_word(pick_word(), noisy ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(0, 4)), 1'b1);
                else
                    send_word(pick_word(), noisy ? 3'($urandom_range(0, 7)) : FULL_WORD, 1'b0);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on = 1'b1;
        test_reset_seed();
        test_tail_counts();
        test_nonlast_counts();
        test_data_extremes();
        test_seed_extremes();
        test_seed_mid_message();

        set_seed($urandom);
        test_random_traffic(400, 1'b1);
        set_seed(32'h0000_0000);
        test_random_traffic(300, 1'b1);
        set_seed(32'hffff_ffff);
        test_random_traffic(300, 1'b1);
        set_seed($urandom);
        test_random_traffic(350, 1'b1);
        // closing stretch at full rate on both sides
        set_seed($urandom);
        test_random_traffic(400, 1'b0);

        stream_hold();
        wait_drained();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/mh3_pkg.sv
sv/mh3_ctrl.sv
sv/mh3_datapath.sv
sv/murmur3_hash_32.sv
tb/sv/murmur3_hash_32_tb.sv
